FILE: hw/rtl/arp_request_responder_defines.svh
// Assertion macros shared by the checker files of the ARP responder.
`ifndef ARP_REQUEST_RESPONDER_DEFINES_SVH
`define ARP_REQUEST_RESPONDER_DEFINES_SVH

// Check that cons holds in the cycle after ante, with reset masking the check.
`define ARP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same check, but live through reset as well.
`define ARP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/arp_pkg.sv
// Shared types, constants and frame layout helpers of the ARP responder.
package arp_pkg;

   localparam int FRAME_BYTES = 42;
   localparam int POS_W       = 6;
   localparam int REPLY_IDX_W = $clog2(FRAME_BYTES);

   localparam logic [POS_W-1:0] POS_MAX  = '1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   // Byte offsets within the frame
   localparam int OFS_SRC_MAC = 6;
   localparam int OFS_TYPE    = 12;
   localparam int OFS_SND_MAC = 22;
   localparam int OFS_SND_IP  = 28;
   localparam int OFS_TGT_MAC = 32;
   localparam int OFS_TGT_IP  = 38;

   localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
   localparam logic [15:0] HTYPE_ETH    = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  HLEN_MAC     = 8'd6;
   localparam logic [7:0]  PLEN_IPV4    = 8'd4;
   localparam logic [15:0] OPER_REQUEST = 16'h0001;
   localparam logic [15:0] OPER_REPLY   = 16'h0002;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 3;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_MAC = '0;

   typedef struct packed {
      logic [47:0] dst_mac;
      logic [47:0] tgt_mac;
      logic [31:0] snd_ip;
      logic [31:0] tgt_ip;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Fixed header byte k (0..9) from the ethertype onwards
   function automatic logic [7:0] header_byte(int k, logic reply);
      logic [7:0] hb;
      case (k)
         0: hb = ETH_TYPE_ARP[15:8];
         1: hb = ETH_TYPE_ARP[7:0];
         2: hb = HTYPE_ETH[15:8];
         3: hb = HTYPE_ETH[7:0];
         4: hb = PTYPE_IPV4[15:8];
         5: hb = PTYPE_IPV4[7:0];
         6: hb = HLEN_MAC;
         7: hb = PLEN_IPV4;
         8: hb = reply ? OPER_REPLY[15:8] : OPER_REQUEST[15:8];
         9: hb = reply ? OPER_REPLY[7:0] : OPER_REQUEST[7:0];
         default: hb = 8'h00;
      endcase
      return hb;
   endfunction

endpackage

FILE: hw/rtl/arp_req_if.sv
// Request channel: received frame bytes with an end-of-frame mark.
interface arp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_last;

   modport source (output valid, data_byte, frame_last, input ready);
   modport sink (input valid, data_byte, frame_last, output ready);
endinterface

FILE: hw/rtl/arp_rsp_if.sv
// Response channel: reply frame bytes with an end-of-frame mark.
interface arp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;

   modport source (output valid, reply_byte, reply_last, input ready);
   modport sink (input valid, reply_byte, reply_last, output ready);
endinterface

FILE: hw/rtl/arp_parser.sv
// Front end: tracks byte position, captures addresses and checks the ARP header.
module arp_parser (
   input  logic                       clock,
   input  logic                       reset,
   arp_req_if.sink                    req,
   input  arp_pkg::queue_status_type  q_status,
   output logic                       push,
   output arp_pkg::job_type           job
);
   import arp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             match_ff, match_in;
   logic [47:0]      src_mac_ff, src_mac_in;
   logic [47:0]      snd_mac_ff, snd_mac_in;
   logic [31:0]      snd_ip_ff, snd_ip_in;
   logic [31:0]      tgt_ip_ff, tgt_ip_in;
   logic             accept;
   int               pos_i;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign pos_i     = int'(pos_ff);

   always_comb begin
      pos_in     = pos_ff;
      match_in   = match_ff;
      src_mac_in = src_mac_ff;
      snd_mac_in = snd_mac_ff;
      snd_ip_in  = snd_ip_ff;
      tgt_ip_in  = tgt_ip_ff;
      if (accept) begin
         if (pos_i inside {[OFS_SRC_MAC:OFS_TYPE-1]}) begin
            src_mac_in = {src_mac_ff[39:0], req.data_byte};
         end else if (pos_i inside {[OFS_TYPE:OFS_SND_MAC-1]}) begin
            if (req.data_byte != header_byte(pos_i - OFS_TYPE, 1'b0)) begin
               match_in = 1'b0;
            end
         end else if (pos_i inside {[OFS_SND_MAC:OFS_SND_IP-1]}) begin
            snd_mac_in = {snd_mac_ff[39:0], req.data_byte};
         end else if (pos_i inside {[OFS_SND_IP:OFS_TGT_MAC-1]}) begin
            snd_ip_in = {snd_ip_ff[23:0], req.data_byte};
         end else if (pos_i inside {[OFS_TGT_IP:FRAME_BYTES-1]}) begin
            tgt_ip_in = {tgt_ip_ff[23:0], req.data_byte};
         end
         if (req.frame_last) begin
            pos_in   = '0;
            match_in = 1'b1;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // The last target IP byte arrives with the final byte, so hand over the new captures
   assign push = accept && req.frame_last && (pos_ff >= LAST_POS) && match_ff;
   assign job  = '{dst_mac: src_mac_in, tgt_mac: snd_mac_in,
                   snd_ip: snd_ip_in, tgt_ip: tgt_ip_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= 1'b1;
      end else begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      src_mac_ff <= src_mac_in;
      snd_mac_ff <= snd_mac_in;
      snd_ip_ff  <= snd_ip_in;
      tgt_ip_ff  <= tgt_ip_in;
   end

endmodule

FILE: hw/rtl/arp_queue.sv
// Short register queue of pending reply jobs between parser and serialiser.
module arp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  arp_pkg::job_type           push_job,
   input  logic                       pop,
   output arp_pkg::job_type           head,
   output arp_pkg::queue_status_type  status
);
   import arp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hw/rtl/arp_serialiser.sv
// Back end: builds the reply frame from the head job and sends it a word per cycle while rsp.ready holds.
module arp_serialiser (
   input  logic                       clock,
   input  logic                       reset,
   input  arp_pkg::job_type           head,
   input  arp_pkg::queue_status_type  q_status,
   input  logic [47:0]                own_mac,
   output logic                       pop,
   arp_rsp_if.source                  rsp
);
   import arp_pkg::*;

   localparam logic [REPLY_IDX_W-1:0] LAST_IDX = REPLY_IDX_W'(FRAME_BYTES - 1);

   logic [REPLY_IDX_W-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic                   load;

   function automatic logic [7:0] mac_byte(logic [47:0] m, int k);
      return m[8*(5-k) +: 8];
   endfunction

   function automatic logic [7:0] ip_byte(logic [31:0] a, int k);
      return a[8*(3-k) +: 8];
   endfunction

   function automatic logic [7:0] reply_at(job_type j, logic [47:0] mac, int k);
      logic [7:0] rb;
      if (k inside {[0:OFS_SRC_MAC-1]}) begin
         rb = mac_byte(j.dst_mac, k);
      end else if (k inside {[OFS_SRC_MAC:OFS_TYPE-1]}) begin
         rb = mac_byte(mac, k - OFS_SRC_MAC);
      end else if (k inside {[OFS_TYPE:OFS_SND_MAC-1]}) begin
         rb = header_byte(k - OFS_TYPE, 1'b1);
      end else if (k inside {[OFS_SND_MAC:OFS_SND_IP-1]}) begin
         rb = mac_byte(mac, k - OFS_SND_MAC);
      end else if (k inside {[OFS_SND_IP:OFS_TGT_MAC-1]}) begin
         rb = ip_byte(j.tgt_ip, k - OFS_SND_IP);
      end else if (k inside {[OFS_TGT_MAC:OFS_TGT_IP-1]}) begin
         rb = mac_byte(j.tgt_mac, k - OFS_TGT_MAC);
      end else if (k inside {[OFS_TGT_IP:FRAME_BYTES-1]}) begin
         rb = ip_byte(j.snd_ip, k - OFS_TGT_IP);
      end else begin
         rb = 8'h00;
      end
      return rb;
   endfunction

   // Refill the output word whenever it is empty or being taken
   assign load = !valid_ff || rsp.ready;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         if (!q_status.empty) begin
            valid_in = 1'b1;
            byte_in  = reply_at(head, own_mac, int'(idx_ff));
            last_in  = (idx_ff == LAST_IDX);
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               pop    = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.reply_byte = byte_ff;
   assign rsp.reply_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

FILE: hw/rtl/arp_request_responder.sv
// ARP responder top level: CSR block, parser, job queue and reply serialiser.
// Input: one byte a cycle; the request side stalls only when QUEUE_DEPTH replies are pending.
// Output: a 42-word reply, one word a cycle while rsp_bus.ready holds, set by the serialiser's byte counter.
// The first reply word passes the queue's count register and then the serialiser's output
// register after the final request byte is taken, when no earlier reply is pending.
// Reset clears position, header flag, queue pointers, reply counter, output valid
// and own_mac; captured addresses are not reset.
module arp_request_responder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   arp_req_if.sink                           req_bus,
   arp_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [arp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [arp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [arp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import arp_pkg::*;

   logic [47:0]      own_mac_ff, own_mac_in;
   logic             csr_hit;
   logic             push, pop;
   job_type          push_job, head;
   queue_status_type q_status;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:3] == REG_OWN_MAC);
   assign prdata  = csr_hit ? CSR_DATA_W'(own_mac_ff) : '0;

   always_comb begin
      own_mac_in = own_mac_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         own_mac_in = pwdata[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
      end else begin
         own_mac_ff <= own_mac_in;
      end
   end

   arp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .q_status (q_status),
      .push     (push),
      .job      (push_job)
   );

   arp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   arp_serialiser u_serialiser (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .own_mac  (own_mac_ff),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

endmodule

FILE: hw/rtl/arp_request_responder_checker.sv
// Port-level checks on the ARP responder's reply channel, bound to the top level.
`include "arp_request_responder_defines.svh"

module arp_request_responder_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] reply_byte,
   input logic       reply_last
);

   `ARP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "reply word dropped while stalled")
   `ARP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(reply_byte) && $stable(reply_last), "reply word changed while stalled")
   `ARP_ASSERT_NEXT(a_rsp_burst, clock, reset, rsp_valid && rsp_ready && !reply_last, rsp_valid, "gap inside a reply frame")
   `ARP_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "reply valid out of reset")

endmodule

bind arp_request_responder arp_request_responder_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .reply_byte (rsp_bus.reply_byte),
   .reply_last (rsp_bus.reply_last)
);
